// ===== sv/ffha_pkg.sv =====
// Shared types, constants and helpers for the first-fit heap allocator.
package ffha_pkg;

   // Heap geometry. ALIGN_BYTES must be a power of two.
   localparam int HEAP_BYTES   = 32768;
   localparam int ALIGN_BYTES  = 16;
   localparam int HEADER_BYTES = 32;

   // Byte offsets up to and including HEAP_BYTES.
   localparam int OFS_W = $clog2(HEAP_BYTES + 1);

   // Block starts differ by at least HEADER_BYTES + ALIGN_BYTES; a header
   // slot is the start offset shifted by the largest power of two below that.
   localparam int SLOT_SHIFT = $clog2(HEADER_BYTES + ALIGN_BYTES + 1) - 1;
   localparam int HDR_DEPTH  = (HEAP_BYTES >> SLOT_SHIFT) + 1;
   localparam int IDX_W      = $clog2(HDR_DEPTH);
   localparam int HDR_W      = OFS_W + 1;

   localparam logic [OFS_W-1:0] HEAP_OFS   = OFS_W'(HEAP_BYTES);
   localparam logic [OFS_W-1:0] HDR_OFS    = OFS_W'(HEADER_BYTES);
   localparam logic [OFS_W-1:0] SPLIT_MIN  = OFS_W'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [OFS_W-1:0] ALIGN_MASK = OFS_W'(ALIGN_BYTES - 1);
   localparam logic [OFS_W-1:0] INIT_SIZE  =
      (HEAP_BYTES > HEADER_BYTES) ? OFS_W'(HEAP_BYTES - HEADER_BYTES) : '0;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   // Classified command handed from front to back.
   typedef enum logic [1:0] {
      CMD_ALLOC      = 2'd0,
      CMD_FREE       = 2'd1,
      CMD_ALLOC_REJ  = 2'd2,
      CMD_FREE_REJ   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] request_size;
      logic [14:0] free_address;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] block_address;
      logic [15:0] used_bytes;
   } rsp_word_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [OFS_W-1:0] wanted;
      logic [OFS_W-1:0] addr;
   } cmd_type;

   // Header entry: free flag and payload size in bytes.
   typedef struct packed {
      logic             free;
      logic [OFS_W-1:0] size;
   } hdr_type;

   function automatic logic [IDX_W-1:0] slot_of(input logic [OFS_W-1:0] start);
      logic [OFS_W-1:0] s;
      s = start >> SLOT_SHIFT;
      return IDX_W'(s);
   endfunction

endpackage

// ===== sv/ffha_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/ffha_front.sv =====
// Front end: accepts request words, classifies them and queues commands.
module ffha_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ffha_pkg::req_word_type req_data,
   output logic                  cmd_valid,
   output ffha_pkg::cmd_type     cmd_data,
   input  logic                  cmd_pop
);
   import ffha_pkg::*;

   cmd_type          q_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   cmd_type          cls;
   logic [OFS_W:0]   req_ext;
   logic [OFS_W:0]   rounded;
   logic             push;

   // Classify: reject bad sizes and null frees, round the size up.
   always_comb begin
      req_ext = (OFS_W + 1)'(req_data.request_size);
      rounded = (req_ext + (OFS_W + 1)'(ALIGN_MASK)) & ~((OFS_W + 1)'(ALIGN_MASK));
      cls.wanted = OFS_W'(rounded);
      cls.addr   = OFS_W'(req_data.free_address);
      if (req_data.opcode == OP_FREE) begin
         cls.kind = (req_data.free_address == '0) ? CMD_FREE_REJ : CMD_FREE;
      end else if (req_ext == '0 || req_ext > (OFS_W + 1)'(HEAP_OFS)) begin
         cls.kind = CMD_ALLOC_REJ;
      end else begin
         cls.kind = CMD_ALLOC;
      end
   end

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // Queue pointers.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   property p_no_pop_empty;
      @(posedge clock) disable iff (reset) cmd_pop |-> count_ff != 2'd0;
   endproperty
   a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= 2'(QUEUE_DEPTH);
   endproperty
   a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

   property p_full_no_push;
      @(posedge clock) disable iff (reset)
         (count_ff == 2'(QUEUE_DEPTH) && !cmd_pop) |=> count_ff == 2'(QUEUE_DEPTH);
   endproperty
   a_full_no_push: assert property (p_full_no_push) else $error("full queue lost an entry");
endmodule

// ===== sv/ffha_back.sv =====
// Back end: walks the header chain to allocate or free, holds the result word.
module ffha_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  ffha_pkg::cmd_type      cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::rsp_word_type rsp_data
);
   import ffha_pkg::*;

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_RD    = 6'b000100,
      S_EVAL  = 6'b001000,
      S_SPLIT = 6'b010000,
      S_MERGE = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [OFS_W-1:0] cur_ff, cur_in;
   logic [OFS_W-1:0] cur_size_ff, cur_size_in;
   logic [OFS_W-1:0] prev_ff, prev_in;
   logic [OFS_W-1:0] prev_size_ff, prev_size_in;
   logic             prev_free_ff, prev_free_in;
   logic             succ_ok_ff, succ_ok_in;
   logic [OFS_W-1:0] split_ofs_ff, split_ofs_in;
   logic [OFS_W-1:0] split_size_ff, split_size_in;
   logic [OFS_W-1:0] used_ff, used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   hdr_type          wr_hdr;
   logic [IDX_W-1:0] rd_addr;
   logic [HDR_W-1:0] rd_raw;
   hdr_type          rd_hdr;
   logic [OFS_W-1:0] pay_ofs;
   logic [OFS_W-1:0] next_ofs;
   logic [OFS_W-1:0] rest;
   logic [OFS_W-1:0] merged;
   logic             out_free;
   logic             finish;
   status_type       fin_status;
   logic [OFS_W-1:0] fin_addr;

   ffha_ram #(.WIDTH(HDR_W), .DEPTH(HDR_DEPTH)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_hdr),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_hdr   = rd_raw;
   assign pay_ofs  = cur_ff + HDR_OFS;
   assign next_ofs = cur_ff + HDR_OFS + rd_hdr.size;
   assign rest     = rd_hdr.size - cmd_ff.wanted;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign merged   = cur_size_ff
                   + ((succ_ok_ff && rd_hdr.free) ? (HDR_OFS + rd_hdr.size) : '0);

   // Chain walk and header updates.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      cur_size_in   = cur_size_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      prev_free_in  = prev_free_ff;
      succ_ok_in    = succ_ok_ff;
      split_ofs_in  = split_ofs_ff;
      split_size_in = split_size_ff;
      used_in       = used_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_of(cur_ff);
      wr_hdr        = '{free: 1'b0, size: '0};
      rd_addr       = slot_of(cur_ff);
      finish        = 1'b0;
      fin_status    = ST_DONE;
      fin_addr      = '0;
      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_hdr   = '{free: 1'b1, size: INIT_SIZE};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop      = 1'b1;
               cmd_in       = cmd_data;
               cur_in       = '0;
               prev_free_in = 1'b0;
               case (cmd_data.kind)
                  CMD_ALLOC_REJ: begin
                     finish     = 1'b1;
                     fin_status = ST_NOFIT;
                  end
                  CMD_FREE_REJ: begin
                     finish     = 1'b1;
                     fin_status = ST_IGNORED;
                  end
                  default: state_in = S_RD;
               endcase
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (cmd_ff.kind == CMD_ALLOC) begin
               if (rd_hdr.free && rd_hdr.size >= cmd_ff.wanted) begin
                  wr_en    = 1'b1;
                  finish   = 1'b1;
                  fin_addr = pay_ofs;
                  if (rest >= SPLIT_MIN) begin
                     wr_hdr        = '{free: 1'b0, size: cmd_ff.wanted};
                     used_in       = used_ff + cmd_ff.wanted;
                     split_ofs_in  = pay_ofs + cmd_ff.wanted;
                     split_size_in = rest - HDR_OFS;
                     state_in      = S_SPLIT;
                  end else begin
                     wr_hdr   = '{free: 1'b0, size: rd_hdr.size};
                     used_in  = used_ff + rd_hdr.size;
                     state_in = S_IDLE;
                  end
               end else if (next_ofs >= HEAP_OFS) begin
                  finish     = 1'b1;
                  fin_status = ST_NOFIT;
                  state_in   = S_IDLE;
               end else begin
                  cur_in   = next_ofs;
                  state_in = S_RD;
               end
            end else begin
               if (pay_ofs == cmd_ff.addr) begin
                  if (rd_hdr.free) begin
                     finish     = 1'b1;
                     fin_status = ST_IGNORED;
                     state_in   = S_IDLE;
                  end else begin
                     cur_size_in = rd_hdr.size;
                     used_in     = used_ff - rd_hdr.size;
                     succ_ok_in  = (next_ofs < HEAP_OFS);
                     rd_addr     = slot_of(next_ofs);
                     state_in    = S_MERGE;
                  end
               end else if (pay_ofs > cmd_ff.addr || next_ofs >= HEAP_OFS) begin
                  finish     = 1'b1;
                  fin_status = ST_IGNORED;
                  state_in   = S_IDLE;
               end else begin
                  prev_in      = cur_ff;
                  prev_size_in = rd_hdr.size;
                  prev_free_in = rd_hdr.free;
                  cur_in       = next_ofs;
                  state_in     = S_RD;
               end
            end
         end
         S_SPLIT: begin
            // Tail of the split block becomes a new free block.
            wr_en    = 1'b1;
            wr_addr  = slot_of(split_ofs_ff);
            wr_hdr   = '{free: 1'b1, size: split_size_ff};
            state_in = S_IDLE;
         end
         S_MERGE: begin
            // Join with a free successor, then with a free predecessor.
            wr_en = 1'b1;
            if (prev_free_ff) begin
               wr_addr = slot_of(prev_ff);
               wr_hdr  = '{free: 1'b1, size: prev_size_ff + HDR_OFS + merged};
            end else begin
               wr_hdr  = '{free: 1'b1, size: merged};
            end
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // Result word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = fin_status;
         rsp_in.block_address = 15'(fin_addr);
         rsp_in.used_bytes    = 16'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      cur_size_ff   <= cur_size_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      prev_free_ff  <= prev_free_in;
      succ_ok_ff    <= succ_ok_in;
      split_ofs_ff  <= split_ofs_in;
      split_size_ff <= split_size_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   property p_pop_when_out_free;
      @(posedge clock) disable iff (reset) cmd_pop |-> (!rsp_valid_ff || rsp_ready);
   endproperty
   a_pop_when_out_free: assert property (p_pop_when_out_free)
      else $error("command taken while result word still pending");

   property p_used_bound;
      @(posedge clock) disable iff (reset) used_ff <= HEAP_OFS;
   endproperty
   a_used_bound: assert property (p_used_bound) else $error("used bytes exceed heap");

   property p_no_write_idle;
      @(posedge clock) disable iff (reset) state_ff == S_IDLE |-> !wr_en;
   endproperty
   a_no_write_idle: assert property (p_no_write_idle) else $error("header write while idle");

   property p_finish_out_free;
      @(posedge clock) disable iff (reset) finish |-> (!rsp_valid_ff || rsp_ready);
   endproperty
   a_finish_out_free: assert property (p_finish_out_free)
      else $error("result word overwritten");
endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// Top level: first-fit heap allocator with coalescing of freed blocks.
// A rejected word is answered from the idle state; an allocate or a free walks the header
// chain with one registered header RAM read per header visited, and after a split the back
// end writes the tail header before it takes the next command.
// Throughput: one word at a time in the back end; a 2-entry command queue decouples
// the request side. Reset: synchronous, active high; after reset the back end first
// writes the header at offset 0 as one free block spanning the heap.
module first_fit_heap_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::rsp_word_type rsp_data
);
   import ffha_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   ffha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   ffha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
